// ===== hw/rtl/vtpt_pkg.sv =====
// shared types, codes and field tables for the vector tile tokenizer
package vtpt_pkg;

  localparam int PositionBitsDef = 32;
  localparam int QueueDepth      = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [1:0]  nest_level;
    logic [28:0] field_number;
    logic [63:0] token_value;
    logic        run_end;
    logic [2:0]  error_code;
    logic        last_result;
  } out_rsp_t;

  typedef enum logic [3:0] {
    TK_START    = 4'd0,
    TK_END      = 4'd1,
    TK_UINT     = 4'd2,
    TK_SINT     = 4'd3,
    TK_BOOL     = 4'd4,
    TK_FIX32    = 4'd5,
    TK_FIX64    = 4'd6,
    TK_STRBYTE  = 4'd7,
    TK_EMPTYSTR = 4'd8,
    TK_PACKED   = 4'd9,
    TK_DONE     = 4'd10,
    TK_ERROR    = 4'd11
  } tok_e;

  typedef enum logic [2:0] {
    ERR_TRUNC   = 3'd0,
    ERR_WIRE    = 3'd1,
    ERR_BOUND   = 3'd2,
    ERR_GEOM    = 3'd3,
    ERR_UNKWIRE = 3'd4
  } err_e;

  typedef enum logic [3:0] {
    A_SKIP    = 4'd0,
    A_LAYER   = 4'd1,
    A_FEATURE = 4'd2,
    A_VALUE   = 4'd3,
    A_STR     = 4'd4,
    A_U32     = 4'd5,
    A_U64     = 4'd6,
    A_SINT    = 4'd7,
    A_BOOL    = 4'd8,
    A_GEOM    = 4'd9,
    A_F32     = 4'd10,
    A_F64     = 4'd11,
    A_PACKED  = 4'd12
  } act_e;

  typedef enum logic [7:0] {
    PH_TAG     = 8'b0000_0001,
    PH_VAL     = 8'b0000_0010,
    PH_LEN     = 8'b0000_0100,
    PH_STR     = 8'b0000_1000,
    PH_SKIP    = 8'b0001_0000,
    PH_FIX     = 8'b0010_0000,
    PH_PACKED  = 8'b0100_0000,
    PH_SKIPVAR = 8'b1000_0000
  } ph_e;

  // message kinds on the stack
  localparam logic [1:0] MK_PACKED  = 2'd0;
  localparam logic [1:0] MK_LAYER   = 2'd1;
  localparam logic [1:0] MK_FEATURE = 2'd2;
  localparam logic [1:0] MK_VALUE   = 2'd3;

  // wire types
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  // all results one input byte causes
  typedef struct packed {
    logic            main_vld;
    logic [3:0]      main_kind;
    logic [1:0]      main_level;
    logic [28:0]     main_field;
    logic [63:0]     main_value;
    logic            main_rend;
    logic [1:0]      n_end;
    logic [1:0]      end_top;
    logic [2:0][1:0] end_kind;
    logic            tail_vld;
    logic            tail_err;
    logic [1:0]      tail_level;
    logic [28:0]     tail_field;
    logic [2:0]      tail_code;
  } bundle_t;

  function automatic act_e classify(input logic [1:0] kind, input logic [28:0] fld);
    act_e a;
    a = A_SKIP;
    case (kind)
      MK_PACKED: begin
        if (fld == 29'd3) a = A_LAYER;
      end
      MK_LAYER: begin
        case (fld)
          29'd1, 29'd3:  a = A_STR;
          29'd2:         a = A_FEATURE;
          29'd4:         a = A_VALUE;
          29'd5, 29'd15: a = A_U32;
          default:       a = A_SKIP;
        endcase
      end
      MK_FEATURE: begin
        case (fld)
          29'd1:        a = A_U64;
          29'd2, 29'd4: a = A_PACKED;
          29'd3:        a = A_GEOM;
          default:      a = A_SKIP;
        endcase
      end
      default: begin
        case (fld)
          29'd1:        a = A_STR;
          29'd2:        a = A_F32;
          29'd3:        a = A_F64;
          29'd4, 29'd5: a = A_U64;
          29'd6:        a = A_SINT;
          29'd7:        a = A_BOOL;
          default:      a = A_SKIP;
        endcase
      end
    endcase
    return a;
  endfunction

  function automatic logic [28:0] kind_field(input logic [1:0] kind);
    logic [28:0] f;
    case (kind)
      MK_LAYER:   f = 29'd3;
      MK_FEATURE: f = 29'd2;
      MK_VALUE:   f = 29'd4;
      default:    f = 29'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/vtpt_front.sv =====
// byte parser: varint decode, message stack, at most one result bundle per byte
module vtpt_front #(
  parameter int PositionBits = vtpt_pkg::PositionBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vtpt_pkg::in_req_t in_req_i,
  output logic              bnd_valid_o,
  output vtpt_pkg::bundle_t bnd_o,
  input  logic              bnd_full_i
);
  import vtpt_pkg::*;

  localparam int PB = PositionBits;

  logic [PB-1:0]        pos_q, pos_d, pos_inc;
  logic [2:0][PB-1:0]   end_q, end_d;
  logic [2:0][1:0]      knd_q, knd_d;
  logic [1:0]           dep_q, dep_d;
  logic [31:0]          tag_q, tag_d;
  ph_e                  ph_q, ph_d;
  logic [63:0]          acc_q, acc_d;
  logic [3:0]           sh_q, sh_d;
  logic [PB-1:0]        rem_q, rem_d;
  logic                 err_q, err_d;

  logic                 acc_in;
  logic [7:0]           b;
  logic                 pos_at_max;
  logic [31:0]          lim, pos32, len32;
  logic [63:0]          vb_acc, fx_acc;
  logic [3:0]           vb_sh;
  logic                 vb_done;
  logic                 fits_len, fits4, fits8;
  logic [1:0]           kind_cur;
  act_e                 act_cur, act_tag;
  logic [28:0]          fld;
  logic [2:0]           wt;
  logic                 fail_v;
  err_e                 fail_c;
  logic                 endp;
  bundle_t              bnd;

  assign acc_in     = in_valid_i & ~bnd_full_i;
  assign in_stall_o = bnd_full_i;
  assign b          = in_req_i.data_byte;
  assign pos_at_max = &pos_q;
  assign pos_inc    = pos_q + PB'(1);
  assign pos32      = 32'(pos_inc);
  assign lim        = (dep_q == 2'd0) ? 32'({PB{1'b1}}) : 32'(end_q[dep_q - 2'd1]);

  // one varint group merged into the accumulator
  assign vb_acc  = acc_q | ((sh_q < 4'd10) ? (64'(b[6:0]) << (7 * sh_q)) : 64'd0);
  assign vb_sh   = (sh_q < 4'd15) ? sh_q + 4'd1 : sh_q;
  assign vb_done = ~b[7];
  assign fx_acc  = acc_q | (64'(b) << {sh_q[2:0], 3'b000});
  assign len32   = vb_acc[31:0];

  assign fits_len = ({1'b0, pos32} + {1'b0, len32}) <= {1'b0, lim};
  assign fits4    = ({1'b0, pos32} + 33'd4) <= {1'b0, lim};
  assign fits8    = ({1'b0, pos32} + 33'd8) <= {1'b0, lim};

  assign kind_cur = (dep_q == 2'd0) ? MK_PACKED : knd_q[dep_q - 2'd1];
  assign fld      = tag_q[31:3];
  assign act_cur  = classify(kind_cur, fld);
  assign act_tag  = classify(kind_cur, vb_acc[31:3]);
  assign wt       = vb_acc[2:0];

  always_comb begin
    pos_d  = pos_q;
    end_d  = end_q;
    knd_d  = knd_q;
    dep_d  = dep_q;
    tag_d  = tag_q;
    ph_d   = ph_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    err_d  = err_q;
    bnd    = '0;
    fail_v = 1'b0;
    fail_c = ERR_TRUNC;
    endp   = 1'b0;

    if (err_q) begin
      if (!pos_at_max) pos_d = pos_inc;
    end else begin
      if (pos_at_max) begin
        fail_v = 1'b1;
        fail_c = ERR_BOUND;
      end else begin
        pos_d = pos_inc;
        case (ph_q)
          PH_VAL, PH_SKIPVAR: begin
            acc_d = vb_acc;
            sh_d  = vb_sh;
            if (vb_done) begin
              acc_d = '0;
              sh_d  = '0;
              ph_d  = PH_TAG;
              if (ph_q == PH_VAL) begin
                bnd.main_level = dep_q;
                bnd.main_field = fld;
                case (act_cur)
                  A_U32: begin
                    bnd.main_vld   = 1'b1;
                    bnd.main_kind  = TK_UINT;
                    bnd.main_value = 64'(vb_acc[31:0]);
                  end
                  A_U64: begin
                    bnd.main_vld   = 1'b1;
                    bnd.main_kind  = TK_UINT;
                    bnd.main_value = vb_acc;
                  end
                  A_SINT: begin
                    bnd.main_vld   = 1'b1;
                    bnd.main_kind  = TK_SINT;
                    bnd.main_value = (vb_acc >> 1) ^ {64{vb_acc[0]}};
                  end
                  A_BOOL: begin
                    bnd.main_vld   = 1'b1;
                    bnd.main_kind  = TK_BOOL;
                    bnd.main_value = 64'(|vb_acc);
                  end
                  A_GEOM: begin
                    if (|vb_acc[31:2]) begin
                      fail_v = 1'b1;
                      fail_c = ERR_GEOM;
                    end else begin
                      bnd.main_vld   = 1'b1;
                      bnd.main_kind  = TK_UINT;
                      bnd.main_value = 64'(vb_acc[31:0]);
                    end
                  end
                  A_PACKED: begin
                    bnd.main_vld   = 1'b1;
                    bnd.main_kind  = TK_PACKED;
                    bnd.main_level = 2'd3;
                    bnd.main_value = 64'(vb_acc[31:0]);
                    bnd.main_rend  = 1'b1;
                  end
                  default: ;
                endcase
              end
            end
          end
          PH_LEN: begin
            acc_d = vb_acc;
            sh_d  = vb_sh;
            if (vb_done) begin
              acc_d = '0;
              sh_d  = '0;
              ph_d  = PH_TAG;
              if (!fits_len) begin
                fail_v = 1'b1;
                fail_c = ERR_BOUND;
              end else begin
                case (act_cur)
                  A_LAYER, A_FEATURE, A_VALUE: begin
                    if (dep_q == 2'd3) begin
                      fail_v = 1'b1;
                      fail_c = ERR_BOUND;
                    end else begin
                      end_d[dep_q]   = pos_inc + len32[PB-1:0];
                      knd_d[dep_q]   = (act_cur == A_LAYER)   ? MK_LAYER :
                                       (act_cur == A_FEATURE) ? MK_FEATURE : MK_VALUE;
                      dep_d          = dep_q + 2'd1;
                      bnd.main_vld   = 1'b1;
                      bnd.main_kind  = TK_START;
                      bnd.main_level = dep_q + 2'd1;
                      bnd.main_field = fld;
                      bnd.main_value = 64'(len32);
                    end
                  end
                  A_STR: begin
                    if (len32 == 32'd0) begin
                      bnd.main_vld   = 1'b1;
                      bnd.main_kind  = TK_EMPTYSTR;
                      bnd.main_level = dep_q;
                      bnd.main_field = fld;
                      bnd.main_rend  = 1'b1;
                    end else begin
                      rem_d = len32[PB-1:0];
                      ph_d  = PH_STR;
                    end
                  end
                  A_PACKED: begin
                    if (len32 != 32'd0) begin
                      if (dep_q == 2'd3) begin
                        fail_v = 1'b1;
                        fail_c = ERR_BOUND;
                      end else begin
                        end_d[dep_q] = pos_inc + len32[PB-1:0];
                        knd_d[dep_q] = MK_PACKED;
                        dep_d        = dep_q + 2'd1;
                        ph_d         = PH_PACKED;
                      end
                    end
                  end
                  default: begin
                    if (len32 != 32'd0) begin
                      rem_d = len32[PB-1:0];
                      ph_d  = PH_SKIP;
                    end
                  end
                endcase
              end
            end
          end
          PH_STR: begin
            bnd.main_vld   = 1'b1;
            bnd.main_kind  = TK_STRBYTE;
            bnd.main_level = dep_q;
            bnd.main_field = fld;
            bnd.main_value = 64'(b);
            bnd.main_rend  = (rem_q == PB'(1));
            rem_d          = rem_q - PB'(1);
            if (rem_q == PB'(1)) ph_d = PH_TAG;
          end
          PH_SKIP: begin
            rem_d = rem_q - PB'(1);
            if (rem_q == PB'(1)) ph_d = PH_TAG;
          end
          PH_FIX: begin
            acc_d = fx_acc;
            sh_d  = sh_q + 4'd1;
            rem_d = rem_q - PB'(1);
            if (rem_q == PB'(1)) begin
              acc_d          = '0;
              sh_d           = '0;
              ph_d           = PH_TAG;
              bnd.main_vld   = 1'b1;
              bnd.main_level = dep_q;
              bnd.main_field = fld;
              if (tag_q[2:0] == WT_FIX32) begin
                bnd.main_kind  = TK_FIX32;
                bnd.main_value = 64'(fx_acc[31:0]);
              end else begin
                bnd.main_kind  = TK_FIX64;
                bnd.main_value = fx_acc;
              end
            end
          end
          PH_PACKED: begin
            acc_d = vb_acc;
            sh_d  = vb_sh;
            if (vb_done) begin
              endp           = (dep_q == 2'd3) && (pos_inc == end_q[2]);
              acc_d          = '0;
              sh_d           = '0;
              bnd.main_vld   = 1'b1;
              bnd.main_kind  = TK_PACKED;
              bnd.main_level = 2'd3;
              bnd.main_field = fld;
              bnd.main_value = 64'(vb_acc[31:0]);
              bnd.main_rend  = endp;
              if (endp) begin
                dep_d = 2'd2;
                ph_d  = PH_TAG;
              end
            end
          end
          default: begin
            ph_d  = PH_TAG;
            acc_d = vb_acc;
            sh_d  = vb_sh;
            if (vb_done) begin
              tag_d = vb_acc[31:0];
              acc_d = '0;
              sh_d  = '0;
              case (act_tag)
                A_SKIP: begin
                  if (wt == WT_VARINT) ph_d = PH_SKIPVAR;
                  else if (wt == WT_LEN) ph_d = PH_LEN;
                  else if (wt == WT_FIX64) begin
                    if (!fits8) begin
                      fail_v = 1'b1;
                      fail_c = ERR_BOUND;
                    end else begin
                      rem_d = PB'(8);
                      ph_d  = PH_SKIP;
                    end
                  end else if (wt == WT_FIX32) begin
                    if (!fits4) begin
                      fail_v = 1'b1;
                      fail_c = ERR_BOUND;
                    end else begin
                      rem_d = PB'(4);
                      ph_d  = PH_SKIP;
                    end
                  end else begin
                    fail_v = 1'b1;
                    fail_c = ERR_UNKWIRE;
                  end
                end
                A_LAYER, A_FEATURE, A_VALUE, A_STR: begin
                  if (wt != WT_LEN) begin
                    fail_v = 1'b1;
                    fail_c = ERR_WIRE;
                  end else ph_d = PH_LEN;
                end
                A_F32: begin
                  if (wt != WT_FIX32) begin
                    fail_v = 1'b1;
                    fail_c = ERR_WIRE;
                  end else if (!fits4) begin
                    fail_v = 1'b1;
                    fail_c = ERR_BOUND;
                  end else begin
                    rem_d = PB'(4);
                    ph_d  = PH_FIX;
                  end
                end
                A_F64: begin
                  if (wt != WT_FIX64) begin
                    fail_v = 1'b1;
                    fail_c = ERR_WIRE;
                  end else if (!fits8) begin
                    fail_v = 1'b1;
                    fail_c = ERR_BOUND;
                  end else begin
                    rem_d = PB'(8);
                    ph_d  = PH_FIX;
                  end
                end
                A_PACKED: begin
                  if (wt == WT_VARINT) ph_d = PH_VAL;
                  else if (wt == WT_LEN) ph_d = PH_LEN;
                  else begin
                    fail_v = 1'b1;
                    fail_c = ERR_WIRE;
                  end
                end
                default: begin
                  if (wt != WT_VARINT) begin
                    fail_v = 1'b1;
                    fail_c = ERR_WIRE;
                  end else ph_d = PH_VAL;
                end
              endcase
            end
          end
        endcase
      end

      // close messages that end on this byte, or flag a field that straddles an end
      if (!fail_v) begin
        bnd.end_top = dep_d;
        if (ph_d == PH_TAG && sh_d == 4'd0) begin
          for (int i = 0; i < 3; i++) begin
            if (dep_d != 2'd0 && pos_inc == end_d[dep_d - 2'd1]) begin
              bnd.end_kind[i] = knd_d[dep_d - 2'd1];
              dep_d           = dep_d - 2'd1;
              bnd.n_end       = bnd.n_end + 2'd1;
            end
          end
        end else if (dep_d != 2'd0 && pos_inc == end_d[dep_d - 2'd1]) begin
          fail_v = 1'b1;
          fail_c = ERR_BOUND;
        end
      end

      if (in_req_i.last && !fail_v) begin
        if (ph_d == PH_TAG && sh_d == 4'd0 && dep_d == 2'd0) begin
          bnd.tail_vld = 1'b1;
        end else begin
          fail_v = 1'b1;
          fail_c = ERR_TRUNC;
        end
      end

      if (fail_v) begin
        bnd.tail_vld   = 1'b1;
        bnd.tail_err   = 1'b1;
        bnd.tail_level = dep_d;
        bnd.tail_field = tag_d[31:3];
        bnd.tail_code  = fail_c;
        err_d          = 1'b1;
      end
    end

    // end of buffer: back to the reset state
    if (in_req_i.last) begin
      pos_d = '0;
      end_d = '0;
      knd_d = '0;
      dep_d = '0;
      tag_d = '0;
      ph_d  = PH_TAG;
      acc_d = '0;
      sh_d  = '0;
      rem_d = '0;
      err_d = 1'b0;
    end
  end

  assign bnd_o       = bnd;
  assign bnd_valid_o = in_valid_i & (bnd.main_vld | (bnd.n_end != 2'd0) | bnd.tail_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      end_q <= '0;
      knd_q <= '0;
      dep_q <= '0;
      tag_q <= '0;
      ph_q  <= PH_TAG;
      acc_q <= '0;
      sh_q  <= '0;
      rem_q <= '0;
      err_q <= 1'b0;
    end else if (acc_in) begin
      pos_q <= pos_d;
      end_q <= end_d;
      knd_q <= knd_d;
      dep_q <= dep_d;
      tag_q <= tag_d;
      ph_q  <= ph_d;
      acc_q <= acc_d;
      sh_q  <= sh_d;
      rem_q <= rem_d;
      err_q <= err_d;
    end
  end

`ifndef SYNTHESIS
  a_top_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_q == 2'd3 |-> knd_q[2] == MK_PACKED)
    else $error("third stack entry is not a packed run");

  a_packed_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_PACKED |-> dep_q == 2'd3)
    else $error("packed phase without packed stack entry");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in && in_req_i.last |=> dep_q == 2'd0 && !err_q && ph_q == PH_TAG)
    else $error("state not cleared after final byte");
`endif

endmodule

// ===== hw/rtl/vtpt_queue.sv =====
// short bundle queue between parser and token sequencer
module vtpt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  input  vtpt_pkg::bundle_t wr_bnd_i,
  output logic              full_o,
  output logic              rd_valid_o,
  output vtpt_pkg::bundle_t rd_bnd_o,
  input  logic              rd_pop_i
);
  import vtpt_pkg::*;

  localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntBits = $clog2(QueueDepth + 1);

  bundle_t              mem_q [QueueDepth];
  logic [PtrBits-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 push, pop;

  assign full_o     = (cnt_q == CntBits'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_bnd_o   = mem_q[rd_q];
  assign push       = wr_valid_i & ~full_o;
  assign pop        = rd_pop_i & rd_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_q + PtrBits'(1);
    if (pop)  rd_d = (rd_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_q + PtrBits'(1);
    if (push && !pop) cnt_d = cnt_q + CntBits'(1);
    else if (pop && !push) cnt_d = cnt_q - CntBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= wr_bnd_i;
  end

endmodule

// ===== hw/rtl/vtpt_back.sv =====
// token sequencer: walks one bundle into single results behind an output register
module vtpt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  vtpt_pkg::bundle_t  q_bnd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vtpt_pkg::out_rsp_t out_rsp_o
);
  import vtpt_pkg::*;

  logic [4:0] slots, act, sel, done_q, done_d;
  logic       is_last, load;
  logic       out_vld_q, out_vld_d;
  out_rsp_t   out_q, rsp;

  // slot order: main token, up to three message ends, done or error
  assign slots = {q_bnd_i.tail_vld,
                  q_bnd_i.n_end == 2'd3,
                  q_bnd_i.n_end >= 2'd2,
                  q_bnd_i.n_end != 2'd0,
                  q_bnd_i.main_vld};
  assign act     = slots & ~done_q;
  assign sel     = act & (~act + 5'd1);
  assign is_last = ((act & ~sel) == 5'd0);
  assign load    = q_valid_i & (~out_vld_q | ~out_stall_i);
  assign q_pop_o = load & is_last;

  always_comb begin
    rsp             = '0;
    rsp.last_result = is_last;
    if (sel[0]) begin
      rsp.token_kind   = q_bnd_i.main_kind;
      rsp.nest_level   = q_bnd_i.main_level;
      rsp.field_number = q_bnd_i.main_field;
      rsp.token_value  = q_bnd_i.main_value;
      rsp.run_end      = q_bnd_i.main_rend;
    end else if (sel[1]) begin
      rsp.token_kind   = TK_END;
      rsp.nest_level   = q_bnd_i.end_top;
      rsp.field_number = kind_field(q_bnd_i.end_kind[0]);
    end else if (sel[2]) begin
      rsp.token_kind   = TK_END;
      rsp.nest_level   = q_bnd_i.end_top - 2'd1;
      rsp.field_number = kind_field(q_bnd_i.end_kind[1]);
    end else if (sel[3]) begin
      rsp.token_kind   = TK_END;
      rsp.nest_level   = q_bnd_i.end_top - 2'd2;
      rsp.field_number = kind_field(q_bnd_i.end_kind[2]);
    end else if (q_bnd_i.tail_err) begin
      rsp.token_kind   = TK_ERROR;
      rsp.nest_level   = q_bnd_i.tail_level;
      rsp.field_number = q_bnd_i.tail_field;
      rsp.error_code   = q_bnd_i.tail_code;
    end else begin
      rsp.token_kind   = TK_DONE;
    end
  end

  always_comb begin
    done_d    = done_q;
    out_vld_d = out_vld_q;
    if (load) begin
      done_d    = is_last ? 5'd0 : (done_q | sel);
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      done_q    <= done_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= rsp;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== hw/rtl/vector_tile_protobuf_tokenizer.sv =====
// top level of the vector tile protobuf tokenizer
//
// in channel: one buffer byte per request (data_byte, last), in_valid_i/in_stall_o.
// out channel: one token per request, out_valid_o/out_stall_i; last_result marks
// the final token a byte causes, and a byte may cause none at all.
// a byte is parsed in the cycle it is taken; its results go as one bundle into a
// two-entry queue, and its tokens are sent one per cycle while out_stall_i is
// low, passing the queue and then an output register on their way out.
// throughput: one byte per cycle while each byte yields at most one token and
// out_stall_i is low; a byte yielding more tokens holds the output longer,
// and the queue takes up the difference until it fills and in_stall_o rises.
// a stalled receiver keeps the output register; the parser goes on until the
// queue is full.
// reset clears the parser to the start of a buffer and drops queued tokens;
// the byte marked last also returns the parser to that state.
// after an error no tokens are sent up to and including the byte marked last.
module vector_tile_protobuf_tokenizer #(
  parameter int PositionBits = vtpt_pkg::PositionBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vtpt_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vtpt_pkg::out_rsp_t out_rsp_o
);
  import vtpt_pkg::*;

  logic    fq_valid, fq_full, qb_valid, qb_pop;
  bundle_t fq_bnd, qb_bnd;

  vtpt_front #(
    .PositionBits(PositionBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .bnd_valid_o(fq_valid),
    .bnd_o      (fq_bnd),
    .bnd_full_i (fq_full)
  );

  vtpt_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fq_valid),
    .wr_bnd_i  (fq_bnd),
    .full_o    (fq_full),
    .rd_valid_o(qb_valid),
    .rd_bnd_o  (qb_bnd),
    .rd_pop_i  (qb_pop)
  );

  vtpt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (qb_valid),
    .q_bnd_i    (qb_bnd),
    .q_pop_o    (qb_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

// ===== tb/tb.sv =====
// testbench for the vector tile tokenizer: generated tile buffers against a token predictor
module tb;
  import vtpt_pkg::*;

  typedef logic [7:0] bq_t[$];

  localparam int NumBytes = 410;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  class tile_token_tracker;
    out_rsp_t    pending_tokens[$];
    out_rsp_t    step_tokens[$];
    int          failures;
    logic [31:0] pos;
    logic [31:0] end_ofs[3];
    logic [1:0]  msg_kind[3];
    int          depth;
    logic [31:0] tag;
    ph_e         phase;
    logic [63:0] acc;
    int          shf;
    logic [31:0] remain;
    bit          err_seen;

    function new();
      failures = 0;
      clear_state();
    endfunction

    function void clear_state();
      pos = '0;
      depth = 0;
      tag = '0;
      phase = PH_TAG;
      acc = '0;
      shf = 0;
      remain = '0;
      err_seen = 0;
      for (int i = 0; i < 3; i++) begin
        end_ofs[i] = '0;
        msg_kind[i] = MK_PACKED;
      end
    endfunction

    function void put(tok_e k, int lvl, logic [28:0] f, logic [63:0] v, bit re, err_e c);
      out_rsp_t r;
      if (step_tokens.size() >= 6) return;
      r.token_kind = k;
      r.nest_level = lvl[1:0];
      r.field_number = f;
      r.token_value = v;
      r.run_end = re;
      r.error_code = c;
      r.last_result = 1'b0;
      step_tokens.push_back(r);
    endfunction

    function void raise(err_e c);
      put(TK_ERROR, depth, tag[31:3], '0, 0, c);
      err_seen = 1;
    endfunction

    function logic [1:0] top_kind();
      return (depth == 0) ? MK_PACKED : msg_kind[depth-1];
    endfunction

    function act_e field_action(logic [1:0] k, logic [28:0] f);
      act_e a;
      a = A_SKIP;
      if (k == MK_PACKED) begin
        if (f == 3) a = A_LAYER;
      end else if (k == MK_LAYER) begin
        if (f == 1 || f == 3) a = A_STR;
        else if (f == 2) a = A_FEATURE;
        else if (f == 4) a = A_VALUE;
        else if (f == 5 || f == 15) a = A_U32;
      end else if (k == MK_FEATURE) begin
        if (f == 1) a = A_U64;
        else if (f == 2 || f == 4) a = A_PACKED;
        else if (f == 3) a = A_GEOM;
      end else begin
        if (f == 1) a = A_STR;
        else if (f == 2) a = A_F32;
        else if (f == 3) a = A_F64;
        else if (f == 4 || f == 5) a = A_U64;
        else if (f == 6) a = A_SINT;
        else if (f == 7) a = A_BOOL;
      end
      return a;
    endfunction

    function logic [28:0] msg_field(logic [1:0] k);
      case (k)
        MK_LAYER:   return 29'd3;
        MK_FEATURE: return 29'd2;
        MK_VALUE:   return 29'd4;
        default:    return 29'd0;
      endcase
    endfunction

    function bit fits(logic [31:0] n);
      logic [32:0] stop;
      logic [32:0] limit;
      stop = {1'b0, pos} + {1'b0, n};
      limit = (depth > 0) ? {1'b0, end_ofs[depth-1]} : {1'b0, 32'hFFFF_FFFF};
      return stop <= limit;
    endfunction

    function void start_fixed(logic [31:0] n, ph_e p);
      if (!fits(n)) begin
        raise(ERR_BOUND);
        return;
      end
      acc = '0;
      shf = 0;
      remain = n;
      phase = p;
    endfunction

    function bit open_msg(logic [31:0] len, logic [1:0] k);
      if (depth >= 3) begin
        raise(ERR_BOUND);
        return 0;
      end
      end_ofs[depth] = pos + len;
      msg_kind[depth] = k;
      depth++;
      return 1;
    endfunction

    // base-128 group; groups past the tenth are dropped
    function bit varint_byte(logic [7:0] b);
      if (shf < 10) acc |= 64'(b[6:0]) << (7 * shf);
      if (shf < 15) shf++;
      return !b[7];
    endfunction

    function void on_tag();
      logic [2:0] wt;
      act_e a;
      wt = tag[2:0];
      a = field_action(top_kind(), tag[31:3]);
      case (a)
        A_SKIP: begin
          if (wt == WT_VARINT) phase = PH_SKIPVAR;
          else if (wt == WT_LEN) phase = PH_LEN;
          else if (wt == WT_FIX64) start_fixed(8, PH_SKIP);
          else if (wt == WT_FIX32) start_fixed(4, PH_SKIP);
          else raise(ERR_UNKWIRE);
        end
        A_LAYER, A_FEATURE, A_VALUE, A_STR: begin
          if (wt != WT_LEN) raise(ERR_WIRE);
          else phase = PH_LEN;
        end
        A_F32: begin
          if (wt != WT_FIX32) raise(ERR_WIRE);
          else start_fixed(4, PH_FIX);
        end
        A_F64: begin
          if (wt != WT_FIX64) raise(ERR_WIRE);
          else start_fixed(8, PH_FIX);
        end
        A_PACKED: begin
          if (wt == WT_VARINT) phase = PH_VAL;
          else if (wt == WT_LEN) phase = PH_LEN;
          else raise(ERR_WIRE);
        end
        default: begin
          if (wt != WT_VARINT) raise(ERR_WIRE);
          else phase = PH_VAL;
        end
      endcase
    endfunction

    function void on_value(logic [63:0] v);
      logic [28:0] f;
      f = tag[31:3];
      case (field_action(top_kind(), f))
        A_U32:  put(TK_UINT, depth, f, {32'd0, v[31:0]}, 0, ERR_TRUNC);
        A_U64:  put(TK_UINT, depth, f, v, 0, ERR_TRUNC);
        A_SINT: put(TK_SINT, depth, f, (v >> 1) ^ {64{v[0]}}, 0, ERR_TRUNC);
        A_BOOL: put(TK_BOOL, depth, f, {63'd0, v != 0}, 0, ERR_TRUNC);
        A_GEOM: begin
          if (v[31:0] > 3) raise(ERR_GEOM);
          else put(TK_UINT, depth, f, {32'd0, v[31:0]}, 0, ERR_TRUNC);
        end
        A_PACKED: put(TK_PACKED, 3, f, {32'd0, v[31:0]}, 1, ERR_TRUNC);
        default: ;
      endcase
    endfunction

    function void on_len(logic [31:0] len);
      logic [28:0] f;
      act_e a;
      f = tag[31:3];
      a = field_action(top_kind(), f);
      if (!fits(len)) begin
        raise(ERR_BOUND);
        return;
      end
      case (a)
        A_LAYER:   if (open_msg(len, MK_LAYER)) put(TK_START, depth, f, 64'(len), 0, ERR_TRUNC);
        A_FEATURE: if (open_msg(len, MK_FEATURE))
                     put(TK_START, depth, f, 64'(len), 0, ERR_TRUNC);
        A_VALUE:   if (open_msg(len, MK_VALUE)) put(TK_START, depth, f, 64'(len), 0, ERR_TRUNC);
        A_STR: begin
          if (len == 0) put(TK_EMPTYSTR, depth, f, '0, 1, ERR_TRUNC);
          else begin
            remain = len;
            phase = PH_STR;
          end
        end
        A_PACKED: begin
          if (len != 0 && open_msg(len, MK_PACKED)) phase = PH_PACKED;
        end
        default: begin
          if (len != 0) begin
            remain = len;
            phase = PH_SKIP;
          end
        end
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      logic [63:0] v;
      logic [28:0] f;
      bit          endp;
      f = tag[31:3];
      case (phase)
        PH_VAL, PH_SKIPVAR: begin
          if (varint_byte(b)) begin
            v = acc;
            acc = '0;
            shf = 0;
            if (phase == PH_VAL) begin
              phase = PH_TAG;
              on_value(v);
            end else phase = PH_TAG;
          end
        end
        PH_LEN: begin
          if (varint_byte(b)) begin
            v = acc;
            acc = '0;
            shf = 0;
            phase = PH_TAG;
            on_len(v[31:0]);
          end
        end
        PH_STR: begin
          put(TK_STRBYTE, depth, f, 64'(b), remain == 1, ERR_TRUNC);
          remain--;
          if (remain == 0) phase = PH_TAG;
        end
        PH_SKIP: begin
          remain--;
          if (remain == 0) phase = PH_TAG;
        end
        PH_FIX: begin
          acc |= 64'(b) << (8 * (shf & 7));
          shf = (shf + 1) & 15;
          remain--;
          if (remain == 0) begin
            v = acc;
            acc = '0;
            shf = 0;
            phase = PH_TAG;
            if (tag[2:0] == WT_FIX32) put(TK_FIX32, depth, f, {32'd0, v[31:0]}, 0, ERR_TRUNC);
            else put(TK_FIX64, depth, f, v, 0, ERR_TRUNC);
          end
        end
        PH_PACKED: begin
          if (varint_byte(b)) begin
            endp = (depth == 3 && pos == end_ofs[2]);
            v = acc;
            acc = '0;
            shf = 0;
            put(TK_PACKED, 3, f, {32'd0, v[31:0]}, endp, ERR_TRUNC);
            if (endp) begin
              depth = 2;
              phase = PH_TAG;
            end
          end
        end
        default: begin
          phase = PH_TAG;
          if (varint_byte(b)) begin
            tag = acc[31:0];
            acc = '0;
            shf = 0;
            on_tag();
          end
        end
      endcase
    endfunction

    function void note_byte(in_req_t rq);
      logic [1:0] k;
      step_tokens.delete();
      if (err_seen) begin
        if (rq.last) clear_state();
        else if (pos != 32'hFFFF_FFFF) pos++;
        return;
      end
      if (pos == 32'hFFFF_FFFF) raise(ERR_BOUND);
      else begin
        pos++;
        take_byte(rq.data_byte);
      end
      if (!err_seen) begin
        if (phase == PH_TAG && shf == 0) begin
          while (depth > 0 && pos == end_ofs[depth-1]) begin
            k = msg_kind[depth-1];
            depth--;
            put(TK_END, depth + 1, msg_field(k), '0, 0, ERR_TRUNC);
          end
        end else if (depth > 0 && pos == end_ofs[depth-1]) raise(ERR_BOUND);
      end
      if (rq.last) begin
        if (!err_seen) begin
          if (phase == PH_TAG && shf == 0 && depth == 0) put(TK_DONE, 0, '0, '0, 0, ERR_TRUNC);
          else raise(ERR_TRUNC);
        end
        clear_state();
      end
      if (step_tokens.size() > 0) step_tokens[$].last_result = 1'b1;
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endfunction

    function void check_token(out_rsp_t got);
      out_rsp_t e;
      if (pending_tokens.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected token %h", got);
        return;
      end
      e = pending_tokens.pop_front();
      if (got.token_kind !== e.token_kind || got.nest_level !== e.nest_level ||
          got.field_number !== e.field_number || got.token_value !== e.token_value ||
          got.run_end !== e.run_end || got.error_code !== e.error_code ||
          got.last_result !== e.last_result) begin
        failures++;
        if (failures <= 10)
          $display({"token mismatch: kind %0d/%0d lvl %0d/%0d fld %0d/%0d val %h/%h",
                    " re %b/%b err %0d/%0d lr %b/%b"},
                   e.token_kind, got.token_kind, e.nest_level, got.nest_level,
                   e.field_number, got.field_number, e.token_value, got.token_value,
                   e.run_end, got.run_end, e.error_code, got.error_code,
                   e.last_result, got.last_result);
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_rsp;

  tile_token_tracker tracker;
  int  cycles;
  int  bytes_sent;
  bit  burst;
  bit  hold_req;
  bq_t none;

  vector_tile_protobuf_tokenizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---- buffer builders ----
  function automatic logic [63:0] rnd_val();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic bq_t vint(logic [63:0] v);
    bq_t q;
    do begin
      q.push_back({v > 64'h7f, v[6:0]});
      v = v >> 7;
    end while (v != 0);
    return q;
  endfunction

  function automatic bq_t tagb(logic [28:0] f, logic [2:0] wt);
    return vint({32'd0, f, wt});
  endfunction

  function automatic bq_t rbytes(int n);
    bq_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic bq_t lenf(logic [28:0] f, bq_t body);
    bq_t q;
    q = tagb(f, WT_LEN);
    q = {q, vint(64'(body.size())), body};
    return q;
  endfunction

  function automatic bq_t vfield(logic [28:0] f, logic [63:0] v);
    bq_t q;
    q = tagb(f, WT_VARINT);
    q = {q, vint(v)};
    return q;
  endfunction

  // unknown field of a skippable wire type; field numbers sometimes huge
  function automatic bq_t unknown_field();
    bq_t q;
    logic [28:0] f;
    f = ($urandom_range(0, 3) == 0) ? 29'($urandom) | 29'd16 : 29'($urandom_range(16, 200));
    case ($urandom_range(0, 4))
      0: q = vfield(f, rnd_val());
      1: q = {tagb(f, WT_FIX64), rbytes(8)};
      2: q = {tagb(f, WT_FIX32), rbytes(4)};
      3: q = lenf(f, rbytes($urandom_range(0, 4)));
      default: begin
        // varint running past 64 bits
        q = tagb(f, WT_VARINT);
        repeat ($urandom_range(10, 12)) q.push_back(8'h80 | 8'($urandom));
        q.push_back(8'($urandom_range(0, 127)));
      end
    endcase
    return q;
  endfunction

  function automatic bq_t packed_run(int n);
    bq_t q;
    repeat (n) q = {q, vint(rnd_val())};
    return q;
  endfunction

  function automatic bq_t gen_value();
    bq_t q;
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 7))
        0: q = {q, lenf(1, rbytes($urandom_range(0, 3)))};
        1: q = {q, tagb(2, WT_FIX32), rbytes(4)};
        2: q = {q, tagb(3, WT_FIX64), rbytes(8)};
        3: q = {q, vfield(29'($urandom_range(4, 5)), rnd_val())};
        4: q = {q, vfield(6, rnd_val())};
        5: q = {q, vfield(7, 64'($urandom_range(0, 2)))};
        default: q = {q, unknown_field()};
      endcase
    end
    return q;
  endfunction

  function automatic bq_t gen_feature();
    bq_t q;
    if ($urandom_range(0, 1)) q = vfield(1, rnd_val());
    if ($urandom_range(0, 1)) q = {q, lenf(2, packed_run($urandom_range(0, 3)))};
    q = {q, vfield(3, 64'(($urandom_range(0, 15) == 0) ? $urandom_range(4, 9)
                                                          : $urandom_range(0, 3)))};
    if ($urandom_range(0, 3) == 0) q = {q, vfield(4, rnd_val())};
    else q = {q, lenf(4, packed_run($urandom_range(0, 4)))};
    if ($urandom_range(0, 3) == 0) q = {q, unknown_field()};
    return q;
  endfunction

  function automatic bq_t gen_layer();
    bq_t q;
    q = vfield(15, 64'($urandom_range(1, 2)));
    q = {q, lenf(1, rbytes($urandom_range(0, 3)))};
    repeat ($urandom_range(0, 2)) q = {q, lenf(2, gen_feature())};
    repeat ($urandom_range(0, 2)) q = {q, lenf(3, rbytes($urandom_range(0, 3)))};
    repeat ($urandom_range(0, 2)) q = {q, lenf(4, gen_value())};
    if ($urandom_range(0, 1)) q = {q, vfield(5, rnd_val())};
    if ($urandom_range(0, 3) == 0) q = {q, unknown_field()};
    return q;
  endfunction

  function automatic bq_t gen_tile();
    bq_t q;
    repeat ($urandom_range(1, 2)) q = {q, lenf(3, gen_layer())};
    if ($urandom_range(0, 3) == 0) q = {q, unknown_field()};
    return q;
  endfunction

  // ---- drivers ----
  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_req = '{data_byte: b, last: lst};
    do @(posedge clk_i); while (in_stall);
    tracker.note_byte(in_req);
    bytes_sent++;
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic send_buffer(bq_t q);
    if (q.size() == 0) q.push_back(8'h00);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  initial begin
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      int w;
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      w = burst ? 0 : $urandom_range(0, 6);
      out_stall = (w > 0);
      repeat (w) @(negedge clk_i);
      out_stall = 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_ni && out_valid && !out_stall) tracker.check_token(out_rsp);
  end

  initial begin
    bq_t q;
    tracker = new();
    cycles = 0;
    bytes_sent = 0;
    burst = 1'b0;
    hold_req = 1'b0;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // unknown wire type on the last byte itself
    send_buffer(tagb(1, 3'd3));
    // layer field with a varint wire type
    send_buffer(vfield(3, 0));
    // buffer ends inside an open layer
    send_buffer({tagb(3, WT_LEN), vint(5), tagb(15, WT_VARINT)});
    // geometry type above three
    send_buffer(lenf(3, lenf(2, vfield(3, 7))));
    // string length beyond the layer end
    send_buffer({tagb(3, WT_LEN), vint(2), tagb(1, WT_LEN), vint(5)});
    // packed field as one varint, empty packed run, sint and bool values
    send_buffer(lenf(3, {lenf(2, {vfield(4, 5), lenf(2, none)}),
                         lenf(4, {vfield(6, 3), vfield(7, 2)})}));

    while (bytes_sent < NumBytes) begin
      burst = ($urandom_range(0, 3) == 0);
      if (bytes_sent > 60 && bytes_sent < 200 && !hold_req) begin
        hold_req = 1'b1;
        burst = 1'b1;
      end
      q = gen_tile();
      case ($urandom_range(0, 7))
        0: q = q[0:$urandom_range(0, q.size() - 1)];
        1: q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
        2: q = rbytes($urandom_range(1, 8));
        default: ;
      endcase
      send_buffer(q);
    end

    burst = 1'b0;
    while (tracker.pending_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/vtpt_pkg.sv
hw/rtl/vtpt_front.sv
hw/rtl/vtpt_queue.sv
hw/rtl/vtpt_back.sv
hw/rtl/vector_tile_protobuf_tokenizer.sv
tb/tb.sv
